[src/nvkt_pkg.sv]
package nvkt_pkg;

  // request kinds as they arrive on the input tuser
  localparam logic [1:0] REQ_NOTE_ON    = 2'd0;
  localparam logic [1:0] REQ_NOTE_OFF   = 2'd1;
  localparam logic [1:0] REQ_VOICE_DONE = 2'd2;
  localparam logic [1:0] REQ_CLEAR_ALL  = 2'd3;

  // operation carried by the token through the cell chain
  localparam logic [2:0] OP_NOP   = 3'd0;
  localparam logic [2:0] OP_ON    = 3'd1;
  localparam logic [2:0] OP_OFF   = 3'd2;
  localparam logic [2:0] OP_DONE  = 3'd3;
  localparam logic [2:0] OP_CLEAR = 3'd4;

  localparam int NOTE_W    = 7;
  localparam int VOICE_W   = 4;
  localparam int CHANNEL_W = 4;

  localparam logic [2:0] ADDR_MIDI_CHANNEL = 3'd0;

  typedef struct packed {
    logic                 vld;
    logic [2:0]           op;
    logic                 acc;
    logic [NOTE_W-1:0]    note;
    logic [VOICE_W-1:0]   voice;
    logic                 hit;
    logic [VOICE_W-1:0]   hit_voice;
  } token_t;

  typedef struct packed {
    logic                 accepted;
    logic                 table_full;
    logic                 release_all;
    logic [VOICE_W-1:0]   release_voice;
    logic                 release_valid;
  } result_t;

endpackage

[src/nvkt_cell.sv]
module nvkt_cell (
  input  logic            clk,
  input  logic            rst,
  input  nvkt_pkg::token_t tok_in,
  output nvkt_pkg::token_t tok_out
);

  logic                          used;
  logic                          used_next;
  logic [nvkt_pkg::NOTE_W-1:0]   note;
  logic [nvkt_pkg::VOICE_W-1:0]  voice;
  logic                          wr;
  nvkt_pkg::token_t              tok_next;

  always_comb begin
    tok_next  = tok_in;
    used_next = used;
    wr        = 1'b0;
    if (tok_in.vld) begin
      unique case (tok_in.op)
        nvkt_pkg::OP_ON: begin
          // take the note if this cell is free and no earlier cell did
          if (!tok_in.hit && !used) begin
            used_next    = 1'b1;
            wr           = 1'b1;
            tok_next.hit = 1'b1;
          end
        end
        nvkt_pkg::OP_OFF: begin
          if (!tok_in.hit && used && (note == tok_in.note)) begin
            used_next          = 1'b0;
            tok_next.hit       = 1'b1;
            tok_next.hit_voice = voice;
          end
        end
        nvkt_pkg::OP_DONE: begin
          if (used && (voice == tok_in.voice)) begin
            used_next = 1'b0;
          end
        end
        nvkt_pkg::OP_CLEAR: begin
          used_next = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used        <= 1'b0;
      tok_out.vld <= 1'b0;
    end else begin
      used        <= used_next;
      tok_out.vld <= tok_next.vld;
    end
    tok_out.op        <= tok_next.op;
    tok_out.acc       <= tok_next.acc;
    tok_out.note      <= tok_next.note;
    tok_out.voice     <= tok_next.voice;
    tok_out.hit       <= tok_next.hit;
    tok_out.hit_voice <= tok_next.hit_voice;
    if (wr) begin
      note  <= tok_in.note;
      voice <= tok_in.voice;
    end
  end

endmodule

[src/note_voice_key_table.sv]
// Held-key table: pairs each held MIDI note with the synth voice playing it.
// Input stream (s_*): one beat per event; tuser carries the request kind
// (note on, note off, voice finished, clear all), tdata the channel, note,
// voice and voice-assigned flag. Output stream (m_*): exactly one result beat
// per input beat, in order: release flag and voice, release-all, table-full
// and accepted.
// The APB port holds midi_channel at address 0; write it only while idle.
// Each event is handed as a token down a row of TABLE_ENTRIES cells, one cell
// per cycle, each cell owning one table entry. Each token passes the input
// register and the cells, and its result a holding register, before the
// result beat appears; s_tready returns at the same edge as that beat, so
// the block holds one event at a time and takes the next only once the last
// result has left the holding register.
// A stalled output beat holds; the next event is still taken and its result
// waits in a holding register behind it, with s_tready low until it moves.
// Reset empties the table, sets midi_channel to 0 and drops any beat in
// flight; s_tready is high from the first cycle after reset.
module note_voice_key_table #(
  parameter int TABLE_ENTRIES = 11
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [3:0] channel, [10:4] note, [14:11] voice, [15] voice_assigned
  input  logic [15:0] s_tdata,
  // [1:0] req_type
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [0] release_valid, [4:1] release_voice, [5] release_all,
  // [6] table_full, [7] accepted
  output logic [7:0]  m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [nvkt_pkg::CHANNEL_W-1:0] midi_channel;
  logic                           busy;
  nvkt_pkg::token_t               tok [TABLE_ENTRIES+1];
  nvkt_pkg::token_t               tok_next;
  nvkt_pkg::result_t              res;
  nvkt_pkg::result_t              res_next;
  logic                           res_valid;
  logic                           res_move;
  logic                           in_take;

  logic [1:0]                     in_req;
  logic [nvkt_pkg::CHANNEL_W-1:0] in_channel;
  logic [nvkt_pkg::NOTE_W-1:0]    in_note;
  logic [nvkt_pkg::VOICE_W-1:0]   in_voice;
  logic                           in_assigned;

  assign pready = 1'b1;
  assign prdata = (paddr == nvkt_pkg::ADDR_MIDI_CHANNEL) ? {28'd0, midi_channel} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      midi_channel <= '0;
    end else if (psel && penable && pwrite && pready &&
                 (paddr == nvkt_pkg::ADDR_MIDI_CHANNEL)) begin
      midi_channel <= pwdata[3:0];
    end
  end

  assign in_req      = s_tuser;
  assign in_channel  = s_tdata[3:0];
  assign in_note     = s_tdata[10:4];
  assign in_voice    = s_tdata[14:11];
  assign in_assigned = s_tdata[15];

  assign s_tready = !busy;
  assign in_take  = s_tvalid && s_tready;

  // turn the request into a chain operation
  always_comb begin
    tok_next           = '0;
    tok_next.vld       = in_take;
    tok_next.acc       = 1'b1;
    tok_next.note      = in_note;
    tok_next.voice     = in_voice;
    unique case (in_req)
      nvkt_pkg::REQ_NOTE_ON: begin
        if (in_channel != midi_channel) begin
          tok_next.acc = 1'b0;
          tok_next.op  = nvkt_pkg::OP_NOP;
        end else if (in_assigned) begin
          tok_next.op  = nvkt_pkg::OP_ON;
        end else begin
          tok_next.op  = nvkt_pkg::OP_NOP;
        end
      end
      nvkt_pkg::REQ_NOTE_OFF: begin
        if (in_channel != midi_channel) begin
          tok_next.acc = 1'b0;
          tok_next.op  = nvkt_pkg::OP_NOP;
        end else begin
          tok_next.op  = nvkt_pkg::OP_OFF;
        end
      end
      nvkt_pkg::REQ_VOICE_DONE: tok_next.op = nvkt_pkg::OP_DONE;
      nvkt_pkg::REQ_CLEAR_ALL:  tok_next.op = nvkt_pkg::OP_CLEAR;
      default:                  tok_next.op = nvkt_pkg::OP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok[0].vld <= 1'b0;
    end else begin
      tok[0].vld <= tok_next.vld;
    end
    tok[0].op        <= tok_next.op;
    tok[0].acc       <= tok_next.acc;
    tok[0].note      <= tok_next.note;
    tok[0].voice     <= tok_next.voice;
    tok[0].hit       <= tok_next.hit;
    tok[0].hit_voice <= tok_next.hit_voice;
  end

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    nvkt_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
  end

  // form the result from the token leaving the last cell
  always_comb begin
    res_next               = '0;
    res_next.accepted      = tok[TABLE_ENTRIES].acc;
    res_next.release_all   = (tok[TABLE_ENTRIES].op == nvkt_pkg::OP_CLEAR);
    res_next.table_full    = (tok[TABLE_ENTRIES].op == nvkt_pkg::OP_ON) &&
                             !tok[TABLE_ENTRIES].hit;
    if ((tok[TABLE_ENTRIES].op == nvkt_pkg::OP_OFF) && tok[TABLE_ENTRIES].hit) begin
      res_next.release_valid = 1'b1;
      res_next.release_voice = tok[TABLE_ENTRIES].hit_voice;
    end
  end

  assign res_move = res_valid && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      res_valid <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (in_take) begin
        busy <= 1'b1;
      end else if (res_move) begin
        busy <= 1'b0;
      end
      if (tok[TABLE_ENTRIES].vld) begin
        res_valid <= 1'b1;
      end else if (res_move) begin
        res_valid <= 1'b0;
      end
      if (res_move) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tok[TABLE_ENTRIES].vld) begin
      res <= res_next;
    end
    if (res_move) begin
      m_tdata <= res;
    end
  end

endmodule

[src/nvkt_checker.sv]
module nvkt_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata
);

  // one event in flight: input closes right after a beat is taken
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while an event is in flight");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled output beat changed");

  a_release_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && m_tdata[5]))
    else $error("release and release-all in one beat");

  a_reject_quiet: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[7] |-> (m_tdata[6:0] == 7'd0))
    else $error("rejected event reported an action");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> s_tready && !m_tvalid)
    else $error("block not idle after reset");

endmodule

bind note_voice_key_table nvkt_checker u_nvkt_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

[tb/testbench.sv]
module testbench;

  localparam int CHANNEL_W    = nvkt_pkg::CHANNEL_W;
  localparam int NOTE_W       = nvkt_pkg::NOTE_W;
  localparam int VOICE_W      = nvkt_pkg::VOICE_W;
  localparam int ENTRIES      = 11;
  localparam int LATENCY      = ENTRIES + 2;
  localparam int IDLE_PCT     = 38;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_EVENTS = 340;
  localparam int PHASES       = 5;
  localparam int DIR_ROWS     = 25;

  typedef nvkt_pkg::result_t result_t;

  typedef struct packed {
    logic [1:0]           req;
    logic [CHANNEL_W-1:0] chan;
    logic [NOTE_W-1:0]    note;
    logic [VOICE_W-1:0]   voice;
    logic                 asg;
  } key_event_t;

  typedef struct packed {
    key_event_t ev;
    logic       typed;
    result_t    want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  note_voice_key_table #(.TABLE_ENTRIES(ENTRIES)) u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predicted table contents and channel setting
  logic                 held_used  [ENTRIES];
  logic [NOTE_W-1:0]    held_note  [ENTRIES];
  logic [VOICE_W-1:0]   held_voice [ENTRIES];
  logic [CHANNEL_W-1:0] cur_channel;

  result_t answer_q [$];

  int err_count = 0;
  int n_sent    = 0;
  int n_checked = 0;
  int n_ignored = 0;
  int n_release = 0;
  int n_full    = 0;
  int n_clear   = 0;
  int hold_req  = 0;
  bit calm      = 1'b0;

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * 400000);
    $display("timeout: %0d results still owed", answer_q.size());
    $display("FAIL");
    $finish;
  end

  function automatic result_t mk_result(logic acc, logic full, logic all, logic rel,
                                        logic [VOICE_W-1:0] rv);
    result_t r;
    r.accepted      = acc;
    r.table_full    = full;
    r.release_all   = all;
    r.release_voice = rv;
    r.release_valid = rel;
    return r;
  endfunction

  function automatic dir_row_t dir_row(logic [1:0] req, int ch, int nt, int vc, logic asg,
                                       logic typed, result_t want);
    dir_row_t d;
    d.ev.req   = req;
    d.ev.chan  = CHANNEL_W'(ch);
    d.ev.note  = NOTE_W'(nt);
    d.ev.voice = VOICE_W'(vc);
    d.ev.asg   = asg;
    d.typed    = typed;
    d.want     = want;
    return d;
  endfunction

  function automatic result_t key_table_step(key_event_t ev);
    result_t r;
    bit done;
    r = mk_result(1'b1, 1'b0, 1'b0, 1'b0, '0);
    done = 1'b0;
    case (ev.req)
      nvkt_pkg::REQ_NOTE_ON, nvkt_pkg::REQ_NOTE_OFF: begin
        if (ev.chan != cur_channel) begin
          r.accepted = 1'b0;
        end else if (ev.req == nvkt_pkg::REQ_NOTE_ON) begin
          if (ev.asg) begin
            r.table_full = 1'b1;
            for (int i = 0; i < ENTRIES; i++) begin
              if (!done && !held_used[i]) begin
                held_used[i]  = 1'b1;
                held_note[i]  = ev.note;
                held_voice[i] = ev.voice;
                r.table_full  = 1'b0;
                done = 1'b1;
              end
            end
          end
        end else begin
          // lowest matching entry only
          for (int i = 0; i < ENTRIES; i++) begin
            if (!done && held_used[i] && held_note[i] == ev.note) begin
              held_used[i]    = 1'b0;
              r.release_valid = 1'b1;
              r.release_voice = held_voice[i];
              done = 1'b1;
            end
          end
        end
      end
      nvkt_pkg::REQ_VOICE_DONE: begin
        for (int i = 0; i < ENTRIES; i++)
          if (held_used[i] && held_voice[i] == ev.voice) held_used[i] = 1'b0;
      end
      default: begin
        for (int i = 0; i < ENTRIES; i++) held_used[i] = 1'b0;
        r.release_all = 1'b1;
      end
    endcase
    return r;
  endfunction

  // mostly well-formed events on the live channel, notes half the time from a narrow pool so note offs hit
  function automatic key_event_t rand_event();
    key_event_t ev;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) ev.req = nvkt_pkg::REQ_NOTE_ON;
    else if (pick < 80) ev.req = nvkt_pkg::REQ_NOTE_OFF;
    else if (pick < 96) ev.req = nvkt_pkg::REQ_VOICE_DONE;
    else ev.req = nvkt_pkg::REQ_CLEAR_ALL;
    ev.chan = ($urandom_range(0, 99) < 80) ? cur_channel : CHANNEL_W'($urandom);
    case ($urandom_range(0, 3))
      0: ev.note = NOTE_W'($urandom);
      1: ev.note = $urandom_range(0, 1) ? '1 : '0;
      default: ev.note = NOTE_W'(48 + $urandom_range(0, 7));
    endcase
    ev.voice = VOICE_W'($urandom);
    ev.asg   = ($urandom_range(0, 99) < 85);
    return ev;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    err_count++;
    $display("mismatch at result %0d: %s got %0d want %0d", n_checked, what, got, want);
  endtask

  task automatic send_event(key_event_t ev, result_t want, logic typed);
    result_t pred;
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {ev.asg, ev.voice, ev.note, ev.chan};
    s_tuser  <= ev.req;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pred = key_table_step(ev);
    answer_q.push_back(typed ? want : pred);
    n_sent++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 3) @(posedge clk);
  endtask

  task automatic write_channel(logic [CHANNEL_W-1:0] ch);
    logic [31:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= nvkt_pkg::ADDR_MIDI_CHANNEL;
    pwdata  <= 32'(ch);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    cur_channel = ch;
    // back-to-back read for the readback check
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd !== 32'(ch)) report_mismatch("midi_channel readback", rd, ch);
  endtask

  // receiver: random stalls, one long hold-off on request
  initial begin
    int seen;
    int left;
    seen = 0;
    left = 0;
    forever begin
      @(posedge clk);
      if (hold_req != seen) begin
        seen = hold_req;
        left = HOLD_CYCLES;
      end
      if (left > 0) begin
        left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // result beats against the oldest prediction
  initial begin
    result_t got;
    result_t want;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        got = result_t'(m_tdata);
        if (answer_q.size() == 0) begin
          report_mismatch("result beat with nothing owed", got, 0);
        end else begin
          want = answer_q.pop_front();
          if (got.release_valid !== want.release_valid)
            report_mismatch("release_valid", got.release_valid, want.release_valid);
          if (got.release_voice !== want.release_voice)
            report_mismatch("release_voice", got.release_voice, want.release_voice);
          if (got.release_all !== want.release_all)
            report_mismatch("release_all", got.release_all, want.release_all);
          if (got.table_full !== want.table_full)
            report_mismatch("table_full", got.table_full, want.table_full);
          if (got.accepted !== want.accepted)
            report_mismatch("accepted", got.accepted, want.accepted);
          n_release += want.release_valid;
          n_full    += want.table_full;
          n_clear   += want.release_all;
        end
        n_checked++;
      end
    end
  end

  initial begin
    dir_row_t             dir [DIR_ROWS];
    key_event_t           ev;
    logic [CHANNEL_W-1:0] chans [PHASES];
    int                   useful;
    bit                   held_off;

    for (int i = 0; i < ENTRIES; i++) begin
      held_used[i]  = 1'b0;
      held_note[i]  = '0;
      held_voice[i] = '0;
    end
    cur_channel = '0;

    // reset channel 0 applies to the whole table below
    dir[0]  = dir_row(nvkt_pkg::REQ_NOTE_OFF, 0, 60, 0, 0, 1, mk_result(1, 0, 0, 0, 0));
    dir[1]  = dir_row(nvkt_pkg::REQ_NOTE_ON, 1, 60, 3, 1, 1, '0);
    dir[2]  = dir_row(nvkt_pkg::REQ_NOTE_OFF, 15, 127, 0, 0, 1, '0);
    dir[3]  = dir_row(nvkt_pkg::REQ_NOTE_ON, 0, 0, 0, 1, 1, mk_result(1, 0, 0, 0, 0));
    dir[4]  = dir_row(nvkt_pkg::REQ_NOTE_ON, 0, 127, 15, 1, 1, mk_result(1, 0, 0, 0, 0));
    dir[5]  = dir_row(nvkt_pkg::REQ_NOTE_ON, 0, 64, 5, 0, 1, mk_result(1, 0, 0, 0, 0));
    dir[6]  = dir_row(nvkt_pkg::REQ_NOTE_OFF, 0, 64, 0, 0, 1, mk_result(1, 0, 0, 0, 0));
    dir[7]  = dir_row(nvkt_pkg::REQ_NOTE_OFF, 0, 127, 0, 0, 1, mk_result(1, 0, 0, 1, 15));
    dir[8]  = dir_row(nvkt_pkg::REQ_NOTE_ON, 0, 0, 7, 1, 0, '0);
    dir[9]  = dir_row(nvkt_pkg::REQ_NOTE_OFF, 0, 0, 0, 0, 0, '0);
    dir[10] = dir_row(nvkt_pkg::REQ_NOTE_ON, 0, 10, 1, 1, 0, '0);
    dir[11] = dir_row(nvkt_pkg::REQ_NOTE_ON, 0, 11, 2, 1, 0, '0);
    dir[12] = dir_row(nvkt_pkg::REQ_NOTE_ON, 0, 12, 3, 1, 0, '0);
    dir[13] = dir_row(nvkt_pkg::REQ_NOTE_ON, 0, 13, 4, 1, 0, '0);
    dir[14] = dir_row(nvkt_pkg::REQ_NOTE_ON, 0, 14, 5, 1, 0, '0);
    dir[15] = dir_row(nvkt_pkg::REQ_NOTE_ON, 0, 15, 6, 1, 0, '0);
    dir[16] = dir_row(nvkt_pkg::REQ_NOTE_ON, 0, 16, 7, 1, 0, '0);
    dir[17] = dir_row(nvkt_pkg::REQ_NOTE_ON, 0, 17, 8, 1, 0, '0);
    dir[18] = dir_row(nvkt_pkg::REQ_NOTE_ON, 0, 18, 9, 1, 0, '0);
    dir[19] = dir_row(nvkt_pkg::REQ_NOTE_ON, 0, 19, 10, 1, 0, '0);
    dir[20] = dir_row(nvkt_pkg::REQ_NOTE_ON, 0, 100, 9, 1, 0, '0);
    dir[21] = dir_row(nvkt_pkg::REQ_VOICE_DONE, 9, 99, 7, 1, 0, '0);
    dir[22] = dir_row(nvkt_pkg::REQ_NOTE_OFF, 0, 0, 0, 0, 0, '0);
    dir[23] = dir_row(nvkt_pkg::REQ_CLEAR_ALL, 3, 5, 2, 0, 1, mk_result(1, 0, 1, 0, 0));
    dir[24] = dir_row(nvkt_pkg::REQ_NOTE_OFF, 0, 10, 0, 0, 1, mk_result(1, 0, 0, 0, 0));

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int k = 0; k < DIR_ROWS; k++) send_event(dir[k].ev, dir[k].want, dir[k].typed);
    drain();

    chans = '{4'd15, 4'd0, CHANNEL_W'($urandom), CHANNEL_W'($urandom), 4'd15};
    held_off = 1'b0;
    for (int p = 0; p < PHASES; p++) begin
      write_channel(chans[p]);
      calm = (p == 1);
      useful = 0;
      while (useful < PHASE_EVENTS) begin
        ev = rand_event();
        // stall the output for a long stretch while input keeps coming
        if (p == 2 && useful == PHASE_EVENTS / 3 && !held_off) begin
          hold_req++;
          held_off = 1'b1;
        end
        send_event(ev, '0, 1'b0);
        if ((ev.req == nvkt_pkg::REQ_NOTE_ON || ev.req == nvkt_pkg::REQ_NOTE_OFF) &&
            ev.chan != cur_channel)
          n_ignored++;
        else
          useful++;
      end
      calm = 1'b0;
      drain();
    end

    if (answer_q.size() != 0) report_mismatch("results never delivered", answer_q.size(), 0);
    $display("run covered %0d events (%0d on foreign channels), %0d result beats checked",
             n_sent, n_ignored, n_checked);
    $display("%0d releases, %0d table-full drops, %0d clear-alls, %0d mismatches",
             n_release, n_full, n_clear, err_count);
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
src/nvkt_pkg.sv
src/nvkt_cell.sv
src/note_voice_key_table.sv
src/nvkt_checker.sv
tb/testbench.sv
